// ===== rtl/core/dd_pkg.sv =====
// ----------------------------------------------------------------------------
// Direct DFT package
// Shared widths, pipeline tag and state types, and the twiddle generator.
// ----------------------------------------------------------------------------
package dd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int BIN_W     = 23;
    localparam int INDEX_W   = 6;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ROT_STEPS = 18;

    localparam longint ROT_GAIN   = 64'sd652032874;
    localparam longint PH_HALF    = 64'sh0000_0000_8000_0000;
    localparam longint PH_FULL    = 64'sh0000_0001_0000_0000;
    localparam longint PH_QUARTER = 64'sh0000_0000_4000_0000;
    localparam longint Q15_MAX    = 64'sd32767;
    localparam longint Q15_MIN    = -64'sd32768;

    localparam longint ROT_ANGLE [ROT_STEPS] = '{
        64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
        64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
        64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
        64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D,
        64'sh000028BE, 64'sh0000145F
    };

    typedef enum logic {
        ST_LOAD,
        ST_RUN
    } dd_state_t;

    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic               frame_last;
        logic [INDEX_W-1:0] bin;
    } dd_tag_t;

    function automatic longint dd_to_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > Q15_MAX) begin
            r = Q15_MAX;
        end
        if (r < Q15_MIN) begin
            r = Q15_MIN;
        end
        return r;
    endfunction

    // Returns {cos, sin} in Q1.15 for a phase given in units of 2^-32 turn.
    function automatic logic [PROD_W-1:0] dd_twiddle_fn(input logic [31:0] phase);
        longint z;
        longint x;
        longint y;
        longint nx;
        logic   flip;
        longint cq;
        longint sq;
        z    = longint'(phase);
        x    = ROT_GAIN;
        y    = 64'sd0;
        flip = 1'b0;
        if (z >= PH_HALF) begin
            z = z - PH_FULL;
        end
        if (z > PH_QUARTER) begin
            z    = z - PH_HALF;
            flip = 1'b1;
        end
        else if (z < -PH_QUARTER) begin
            z    = z + PH_HALF;
            flip = 1'b1;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            if (z >= 64'sd0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ROT_ANGLE[i];
            end
            else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ROT_ANGLE[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cq = dd_to_q15(x);
        sq = dd_to_q15(y);
        return {cq[SAMPLE_W-1:0], sq[SAMPLE_W-1:0]};
    endfunction

endpackage

// ===== rtl/core/dd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/dd_twiddle.sv =====
// ----------------------------------------------------------------------------
// Twiddle table
// Constant cosine and sine table built at elaboration, with registered read.
// ----------------------------------------------------------------------------
module dd_twiddle #(
    parameter int POINTS = 64
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [$clog2(POINTS)-1:0]           idx,
    output logic signed [dd_pkg::SAMPLE_W-1:0]  tw_c,
    output logic signed [dd_pkg::SAMPLE_W-1:0]  tw_s
);
    import dd_pkg::*;

    logic [PROD_W-1:0] rom [POINTS];
    logic [PROD_W-1:0] tw_reg;

    for (genvar g = 0; g < POINTS; g++)
    begin : g_rom
        localparam logic [63:0] PH = (64'(g) << 32) / POINTS;
        assign rom[g] = dd_twiddle_fn(PH[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tw_reg <= rom[idx];
        end
    end

    assign tw_c = tw_reg[PROD_W-1:SAMPLE_W];
    assign tw_s = tw_reg[SAMPLE_W-1:0];

endmodule

// ===== rtl/core/dd_seq.sv =====
// ----------------------------------------------------------------------------
// Direct DFT sequencer
// Counts samples into the store, then walks every bin and sample index,
// issuing store and twiddle addresses to the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module dd_seq #(
    parameter int POINTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          adv,
    input  logic                          frame_done,
    output logic                          in_stall,
    output logic                          we,
    output logic [$clog2(POINTS)-1:0]     waddr,
    output logic [$clog2(POINTS)-1:0]     raddr,
    output logic [$clog2(POINTS)-1:0]     tw_idx,
    output dd_pkg::dd_tag_t               issue
);
    import dd_pkg::*;

    localparam int IDX_W = $clog2(POINTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);
    localparam logic [IDX_W:0]   PTS      = (IDX_W + 1)'(POINTS);

    dd_state_t        state_reg, state_next;
    logic [IDX_W-1:0] load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0] f_reg, f_next;
    logic [IDX_W-1:0] t_reg, t_next;
    logic [IDX_W-1:0] m_reg, m_next;
    logic             done_reg, done_next;
    logic [IDX_W:0]   m_sum;
    logic [IDX_W:0]   m_wrap;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            f_reg        <= '0;
            t_reg        <= '0;
            m_reg        <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            f_reg        <= f_next;
            t_reg        <= t_next;
            m_reg        <= m_next;
            done_reg     <= done_next;
        end
    end

    assign m_sum  = {1'b0, m_reg} + {1'b0, f_reg};
    assign m_wrap = (m_sum >= PTS) ? (m_sum - PTS) : m_sum;

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        f_next        = f_reg;
        t_next        = t_reg;
        m_next        = m_reg;
        done_next     = done_reg;
        in_stall      = 1'b1;
        accept        = 1'b0;
        issue         = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
                if (accept)
                begin
                    if (load_cnt_reg == LAST_IDX)
                    begin
                        load_cnt_next = '0;
                        state_next    = ST_RUN;
                        f_next        = '0;
                        t_next        = '0;
                        m_next        = '0;
                        done_next     = 1'b0;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                issue.valid      = !done_reg;
                issue.first      = (t_reg == '0);
                issue.last       = (t_reg == LAST_IDX);
                issue.frame_last = (f_reg == LAST_IDX);
                issue.bin        = INDEX_W'(f_reg);
                if (adv && !done_reg)
                begin
                    if (t_reg == LAST_IDX)
                    begin
                        t_next = '0;
                        m_next = '0;
                        if (f_reg == LAST_IDX)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            f_next = f_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        t_next = t_reg + 1'b1;
                        m_next = m_wrap[IDX_W-1:0];
                    end
                end
                if (frame_done)
                begin
                    state_next = ST_LOAD;
                end
            end
        endcase
    end

    assign we     = accept;
    assign waddr  = load_cnt_reg;
    assign raddr  = t_reg;
    assign tw_idx = m_reg;

endmodule

// ===== rtl/core/dd_mac.sv =====
// ----------------------------------------------------------------------------
// Complex multiply-accumulate pipeline
// Multiplies each stored sample by its twiddle, floors the products to
// Q.15 and sums them per bin. The whole pipeline freezes when adv is low.
// ----------------------------------------------------------------------------
module dd_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  dd_pkg::dd_tag_t                    issue,
    input  logic signed [dd_pkg::SAMPLE_W-1:0] xr,
    input  logic signed [dd_pkg::SAMPLE_W-1:0] xi,
    input  logic signed [dd_pkg::SAMPLE_W-1:0] tw_c,
    input  logic signed [dd_pkg::SAMPLE_W-1:0] tw_s,
    output dd_pkg::dd_tag_t                    res,
    output logic signed [dd_pkg::BIN_W-1:0]    acc_re,
    output logic signed [dd_pkg::BIN_W-1:0]    acc_im
);
    import dd_pkg::*;

    dd_tag_t                  s1_reg, s2_reg, s3_reg;
    logic signed [PROD_W-1:0] p_rc_reg, p_is_reg, p_ic_reg, p_rs_reg;
    logic signed [PROD_W:0]   sum_re, sum_im;
    logic signed [PROD_W:0]   sh_re, sh_im;
    logic signed [BIN_W-1:0]  acc_re_reg, acc_re_next;
    logic signed [BIN_W-1:0]  acc_im_reg, acc_im_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg <= issue;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_rc_reg   <= PROD_W'(xr) * PROD_W'(tw_c);
            p_is_reg   <= PROD_W'(xi) * PROD_W'(tw_s);
            p_ic_reg   <= PROD_W'(xi) * PROD_W'(tw_c);
            p_rs_reg   <= PROD_W'(xr) * PROD_W'(tw_s);
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    always_comb
    begin
        sum_re      = (PROD_W + 1)'(p_rc_reg) + (PROD_W + 1)'(p_is_reg);
        sum_im      = (PROD_W + 1)'(p_ic_reg) - (PROD_W + 1)'(p_rs_reg);
        sh_re       = sum_re >>> (SAMPLE_W - 1);
        sh_im       = sum_im >>> (SAMPLE_W - 1);
        acc_re_next = (s2_reg.first ? '0 : acc_re_reg) + sh_re[BIN_W-1:0];
        acc_im_next = (s2_reg.first ? '0 : acc_im_reg) + sh_im[BIN_W-1:0];
    end

    assign res    = s3_reg;
    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

// ===== rtl/core/direct_dft_top.sv =====
// ----------------------------------------------------------------------------
// Direct DFT top level
// Loads a frame of complex Q1.15 samples and returns every frequency bin.
// ----------------------------------------------------------------------------
// Samples enter on the input channel (in_valid, in_stall, sample_re,
// sample_im), one transfer per cycle, until POINTS samples are held in the
// sample RAM. The block then raises in_stall and computes the bins one after
// another, in order of index, with a single complex multiply-accumulate unit
// that reads one sample and one twiddle per cycle unless the pipeline
// holds. Each bin sums POINTS products. Bins leave on the output channel
// (out_valid, out_stall, bin_re, bin_im, bin_index, last_bin) through an
// output register; last_bin marks the final bin. Once the final bin sits
// in the output register, in_stall falls and the next frame may load while
// that bin waits. When the receiver stalls with a bin waiting and the next
// bin is finished, the whole pipeline holds until the transfer completes.
// Reset empties the pipeline and the output register and starts a new
// frame; the sample RAM needs no clearing, as each frame writes every entry
// before it is read.
// ----------------------------------------------------------------------------
module direct_dft_top #(
    parameter int POINTS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [dd_pkg::SAMPLE_W-1:0] sample_re,
    input  logic signed [dd_pkg::SAMPLE_W-1:0] sample_im,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [dd_pkg::BIN_W-1:0]    bin_re,
    output logic signed [dd_pkg::BIN_W-1:0]    bin_im,
    output logic [dd_pkg::INDEX_W-1:0]         bin_index,
    output logic                               last_bin
);
    import dd_pkg::*;

    localparam int IDX_W = $clog2(POINTS);

    logic                      adv;
    logic                      hold;
    logic                      out_load;
    logic                      frame_done;
    logic                      we;
    logic [IDX_W-1:0]          waddr;
    logic [IDX_W-1:0]          raddr;
    logic [IDX_W-1:0]          tw_idx;
    dd_tag_t                   issue;
    dd_tag_t                   res;
    logic [PROD_W-1:0]         rdata;
    logic signed [SAMPLE_W-1:0] tw_c, tw_s;
    logic signed [BIN_W-1:0]   acc_re, acc_im;

    logic                      out_valid_reg, out_valid_next;
    logic signed [BIN_W-1:0]   bin_re_reg, bin_im_reg;
    logic [INDEX_W-1:0]        bin_index_reg;
    logic                      last_bin_reg;

    assign hold       = res.valid && res.last && out_valid_reg && out_stall;
    assign adv        = !hold;
    assign out_load   = res.valid && res.last && adv;
    assign frame_done = out_load && res.frame_last;

    dd_seq #(.POINTS(POINTS)) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .adv        (adv),
        .frame_done (frame_done),
        .in_stall   (in_stall),
        .we         (we),
        .waddr      (waddr),
        .raddr      (raddr),
        .tw_idx     (tw_idx),
        .issue      (issue)
    );

    dd_ram #(.WIDTH(PROD_W), .DEPTH(POINTS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata ({sample_re, sample_im}),
        .re    (adv),
        .raddr (raddr),
        .rdata (rdata)
    );

    dd_twiddle #(.POINTS(POINTS)) u_twiddle (
        .clk  (clk),
        .en   (adv),
        .idx  (tw_idx),
        .tw_c (tw_c),
        .tw_s (tw_s)
    );

    dd_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .issue  (issue),
        .xr     (rdata[PROD_W-1:SAMPLE_W]),
        .xi     (rdata[SAMPLE_W-1:0]),
        .tw_c   (tw_c),
        .tw_s   (tw_s),
        .res    (res),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            bin_re_reg    <= acc_re;
            bin_im_reg    <= acc_im;
            bin_index_reg <= res.bin;
            last_bin_reg  <= res.frame_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_re    = bin_re_reg;
    assign bin_im    = bin_im_reg;
    assign bin_index = bin_index_reg;
    assign last_bin  = last_bin_reg;

endmodule

// ===== rtl/core/dd_checker.sv =====
// ----------------------------------------------------------------------------
// Direct DFT port checker
// Watches the top-level ports for frame sequencing and output hold errors.
// ----------------------------------------------------------------------------
module dd_checker #(
    parameter int POINTS = 64
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [dd_pkg::BIN_W-1:0]    bin_re,
    input logic signed [dd_pkg::BIN_W-1:0]    bin_im,
    input logic [dd_pkg::INDEX_W-1:0]         bin_index,
    input logic                               last_bin
);
    import dd_pkg::*;

    localparam logic [INDEX_W-1:0] LAST_BIN = INDEX_W'(POINTS - 1);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bin_re) && $stable(bin_im)
            && $stable(bin_index) && $stable(last_bin))
        else $error("Output payload changed while stalled.");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_bin == (bin_index == LAST_BIN)))
        else $error("Final bin flag does not match the bin index.");

    a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid && last_bin) |-> !in_stall)
        else $error("Input still stalled when the final bin appeared.");

    a_no_early_load: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && out_valid |-> last_bin)
        else $error("Input open while bins of the frame are still pending.");

    a_run_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("Computation started without a final sample transfer.");

endmodule

bind direct_dft_top dd_checker #(.POINTS(POINTS)) u_dd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bin_re    (bin_re),
    .bin_im    (bin_im),
    .bin_index (bin_index),
    .last_bin  (last_bin)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Direct DFT testbench
// Streams frames of complex samples into the direct DFT and compares every
// returned bin with a transform that the bench computes itself. The bench
// builds its own twiddle table with the same integer rotation. A queue-fed
// driver and a checking monitor both insert random idle bursts. One frame
// waits until every bin of the previous frame has been taken. Frames cover
// directed extremes, a full-scale constant, real data and random content.
// ----------------------------------------------------------------------------
module tb_top;

    import dd_pkg::SAMPLE_W;
    import dd_pkg::BIN_W;
    import dd_pkg::INDEX_W;

    localparam int POINTS       = 64;
    localparam int FRAMES       = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 200;
    localparam int ROT_STEPS    = 18;
    localparam longint ROT_GAIN = 64'sd652032874;

    localparam longint ROT_ANGLE [ROT_STEPS] = '{
        64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
        64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
        64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
        64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D,
        64'sh000028BE, 64'sh0000145F
    };

    localparam int DIRECTED = 20;
    localparam logic [SAMPLE_W-1:0] DIRECTED_RE [DIRECTED] = '{
        16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF,
        16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h4000,
        16'h0001, 16'h0000, 16'hFFFF, 16'h7FFE, 16'h00FF, 16'h8000
    };
    localparam logic [SAMPLE_W-1:0] DIRECTED_IM [DIRECTED] = '{
        16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
        16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'hAAAA, 16'h5555, 16'hC000,
        16'h0000, 16'h0001, 16'hFFFF, 16'h8001, 16'hFF00, 16'h0000
    };

    typedef struct {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       drain_first;
    } sample_item_t;

    typedef struct packed {
        logic signed [BIN_W-1:0] re_part;
        logic signed [BIN_W-1:0] im_part;
        logic [INDEX_W-1:0]      k;
        logic                    last_flag;
    } dft_bin_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_re = '0;
    logic signed [SAMPLE_W-1:0] sample_im = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [BIN_W-1:0]    bin_re;
    logic signed [BIN_W-1:0]    bin_im;
    logic [INDEX_W-1:0]         bin_index;
    logic                       last_bin;

    sample_item_t               sample_queue [$];
    dft_bin_t                   bins_due [$];
    logic signed [SAMPLE_W-1:0] frame_re [POINTS];
    logic signed [SAMPLE_W-1:0] frame_im [POINTS];
    longint                     tw_cos [POINTS];
    longint                     tw_sin [POINTS];
    int                         frame_fill    = 0;
    int                         bins_pushed   = 0;
    int                         bins_taken    = 0;
    int                         mismatch_count = 0;
    int                         cycle_count   = 0;
    int                         send_idle     = 0;
    int                         recv_idle     = 0;
    logic                       tail_phase    = 1'b0;
    logic                       idling_on;
    sample_item_t               next_item;
    dft_bin_t                   want;

    direct_dft_top #(
        .POINTS(POINTS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample_re(sample_re),
        .sample_im(sample_im),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .bin_re   (bin_re),
        .bin_im   (bin_im),
        .bin_index(bin_index),
        .last_bin (last_bin)
    );

    initial begin
        forever begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    assign idling_on = !tail_phase && ((cycle_count % 2500) < 1700);

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] re, input logic [SAMPLE_W-1:0] im,
                                input logic drain_first);
        sample_item_t item;
        item.re          = re;
        item.im          = im;
        item.drain_first = drain_first;
        sample_queue     = {sample_queue, item};
    endtask

    function automatic logic [SAMPLE_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Stores one sample of the current frame; the sample that completes the
    // frame produces every bin of its transform.
    task automatic dft_load_sample(input logic signed [SAMPLE_W-1:0] re,
                                   input logic signed [SAMPLE_W-1:0] im);
        longint   acc_re;
        longint   acc_im;
        longint   xr;
        longint   xi;
        int       m;
        dft_bin_t b;
        frame_re[frame_fill] = re;
        frame_im[frame_fill] = im;
        frame_fill++;
        if (frame_fill == POINTS) begin
            frame_fill = 0;
            for (int f = 0; f < POINTS; f++) begin
                acc_re = 0;
                acc_im = 0;
                for (int t = 0; t < POINTS; t++) begin
                    m  = (f * t) % POINTS;
                    xr = frame_re[t];
                    xi = frame_im[t];
                    acc_re += (xr * tw_cos[m] + xi * tw_sin[m]) >>> 15;
                    acc_im += (xi * tw_cos[m] - xr * tw_sin[m]) >>> 15;
                end
                b.re_part   = acc_re[BIN_W-1:0];
                b.im_part   = acc_im[BIN_W-1:0];
                b.k         = INDEX_W'(f);
                b.last_flag = (f == POINTS - 1);
                bins_due    = {bins_due, b};
                bins_pushed++;
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && !in_stall) begin
                dft_load_sample(sample_re, sample_im);
            end
            if (!in_valid || !in_stall) begin
                if (send_idle > 0) begin
                    send_idle--;
                    in_valid <= 1'b0;
                end
                else if (sample_queue.size() == 0 ||
                         (sample_queue[0].drain_first && bins_pushed != bins_taken)) begin
                    in_valid <= 1'b0;
                end
                else begin
                    next_item = sample_queue.pop_front();
                    in_valid  <= 1'b1;
                    sample_re <= next_item.re;
                    sample_im <= next_item.im;
                    if (sample_queue.size() < POINTS) begin
                        tail_phase <= 1'b1;
                    end
                    if (idling_on && $urandom_range(0, 4) == 0) begin
                        send_idle = $urandom_range(1, 11);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (bins_due.size() == 0) begin
                    report_mismatch($sformatf("bin %0d arrived with no bin pending", bin_index));
                end
                else begin
                    want = bins_due.pop_front();
                    bins_taken <= bins_taken + 1;
                    if (bin_re !== want.re_part) begin
                        report_mismatch($sformatf("bin %0d real part %0d, expected %0d",
                                                  want.k, bin_re, want.re_part));
                    end
                    if (bin_im !== want.im_part) begin
                        report_mismatch($sformatf("bin %0d imaginary part %0d, expected %0d",
                                                  want.k, bin_im, want.im_part));
                    end
                    if (bin_index !== want.k) begin
                        report_mismatch($sformatf("bin index %0d, expected %0d",
                                                  bin_index, want.k));
                    end
                    if (last_bin !== want.last_flag) begin
                        report_mismatch($sformatf("bin %0d last flag %0b, expected %0b",
                                                  want.k, last_bin, want.last_flag));
                    end
                end
            end
            if (recv_idle > 0) begin
                recv_idle--;
                out_stall <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 11) == 0) begin
                recv_idle = $urandom_range(0, 10);
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        longint                 z;
        longint                 x;
        longint                 y;
        longint                 nx;
        logic                   turned;
        logic [SAMPLE_W-1:0]    dc_re;
        logic [SAMPLE_W-1:0]    dc_im;
        for (int m = 0; m < POINTS; m++) begin
            z      = ((longint'(m) << 32) / POINTS) & 64'hFFFF_FFFF;
            x      = ROT_GAIN;
            y      = 0;
            turned = 1'b0;
            if (z >= 64'sh8000_0000) begin
                z = z - 64'sh1_0000_0000;
            end
            if (z > 64'sh4000_0000) begin
                z      = z - 64'sh8000_0000;
                turned = 1'b1;
            end
            else if (z < -64'sh4000_0000) begin
                z      = z + 64'sh8000_0000;
                turned = 1'b1;
            end
            for (int i = 0; i < ROT_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ROT_ANGLE[i];
                end
                else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ROT_ANGLE[i];
                end
                x = nx;
            end
            if (turned) begin
                x = -x;
                y = -y;
            end
            x = (x + 16384) >>> 15;
            y = (y + 16384) >>> 15;
            tw_cos[m] = (x > 32767) ? 32767 : ((x < -32768) ? -32768 : x);
            tw_sin[m] = (y > 32767) ? 32767 : ((y < -32768) ? -32768 : y);
        end

        // The first frame opens with the field extremes and bit patterns.
        for (int n = 0; n < DIRECTED; n++) begin
            queue_sample(DIRECTED_RE[n], DIRECTED_IM[n], 1'b0);
        end
        for (int n = DIRECTED; n < POINTS; n++) begin
            queue_sample(random_value(), random_value(), 1'b0);
        end
        // A full-scale constant frame drives the largest bin values.
        dc_re = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        dc_im = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        for (int n = 0; n < POINTS; n++) begin
            queue_sample(dc_re, dc_im, 1'b0);
        end
        // Real data; its first sample is held back until the previous frame
        // has been fully read out.
        for (int n = 0; n < POINTS; n++) begin
            queue_sample(random_value(), '0, n == 0);
        end
        for (int f = 3; f < FRAMES; f++) begin
            for (int n = 0; n < POINTS; n++) begin
                queue_sample(random_value(), random_value(), 1'b0);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (sample_queue.size() != 0 || in_valid) begin
            @(negedge clk);
        end
        while (bins_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end
        else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
